@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; expects signals named clock and reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// a signal holds while a beat is stalled
`define ASSERT_HOLD(label, cond, sig) \
   `ASSERT_CLK(label, (cond) |=> $stable(sig))

`endif

@@ hdl/ddo_pkg.sv @@
// shared constants, types and helper functions of the wheel odometry block
// no dependencies; imported by ddo_mul, ddo_div and the top level
`timescale 1ns / 1ps

package ddo_pkg;

   // rotation iterations, capped at the size of the arctangent table
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
   localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_ITERS - 1);

   localparam logic [23:0] WHEEL_BASE_RESET = 24'd35389;
   localparam logic signed [34:0] BAM_PER_RAD = 35'sd683565276;
   localparam logic signed [34:0] USEC = 35'sd1000000;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] POS_MIN = {1'b1, {47{1'b0}}};
   localparam logic signed [49:0] DTH_LIMIT = 50'sd8796093022208;
   localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

   // last multiplier bit index for the two serial operand widths
   localparam logic [5:0] DS_LAST = 6'd32;
   localparam logic [5:0] DTH_LAST = 6'd49;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DELTA, ST_DIV_DTH, ST_MUL_BAM, ST_ROT_MID, ST_MUL_X, ST_MUL_Y,
      ST_POS, ST_ROT_HALF, ST_MUL_VX, ST_DIV_VX, ST_MUL_VTH, ST_DIV_VTH, ST_DONE
   } ddo_state_type;

   typedef struct packed {
      logic       start;
      logic [5:0] last;
   } mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // arctangent of 2^-i as binary angle
   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'h2000_0000;
         5'd1:  a = 32'h12E4_051E;
         5'd2:  a = 32'h09FB_385B;
         5'd3:  a = 32'h0511_11D4;
         5'd4:  a = 32'h028B_0D43;
         5'd5:  a = 32'h0145_D7E1;
         5'd6:  a = 32'h00A2_F61E;
         5'd7:  a = 32'h0051_7C55;
         5'd8:  a = 32'h0028_BE53;
         5'd9:  a = 32'h0014_5F2F;
         5'd10: a = 32'h000A_2F98;
         5'd11: a = 32'h0005_17CC;
         5'd12: a = 32'h0002_8BE6;
         5'd13: a = 32'h0001_45F3;
         5'd14: a = 32'h0000_A2FA;
         5'd15: a = 32'h0000_517D;
         5'd16: a = 32'h0000_28BE;
         5'd17: a = 32'h0000_145F;
         5'd18: a = 32'h0000_0A30;
         5'd19: a = 32'h0000_0518;
         5'd20: a = 32'h0000_028C;
         5'd21: a = 32'h0000_0146;
         5'd22: a = 32'h0000_00A3;
         5'd23: a = 32'h0000_0051;
         5'd24: a = 32'h0000_0029;
         5'd25: a = 32'h0000_0014;
         5'd26: a = 32'h0000_000A;
         5'd27: a = 32'h0000_0005;
         5'd28: a = 32'h0000_0003;
         5'd29: a = 32'h0000_0001;
         5'd30: a = 32'h0000_0001;
         default: a = 32'h0000_0000;
      endcase
      return a;
   endfunction

   // saturate a quotient to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = V_MAX;
      end else if (v < -64'sd2147483648) begin
         r = V_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // round Q4.30 to Q1.15 with saturation
   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [19:0] sh;
      logic signed [15:0] r;
      t = 35'(v) + 35'sd16384;
      sh = 20'(t >>> 15);
      if (sh > 20'sd32767) begin
         r = 16'sh7FFF;
      end else if (sh < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = sh[15:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/ddo_if.sv @@
// valid/ready channel interfaces for reading beats and pose result beats
// no dependencies
`timescale 1ns / 1ps

interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] right_total;
   logic signed [31:0] left_total;
   logic [23:0]        elapsed_us;
   logic               reading_valid;

   modport source (output valid, right_total, left_total, elapsed_us, reading_valid,
                   input ready);
   modport sink (input valid, right_total, left_total, elapsed_us, reading_valid,
                 output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] pos_x;
   logic signed [47:0] pos_y;
   logic signed [31:0] heading_angle;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   logic signed [31:0] linear_velocity;
   logic signed [31:0] angular_velocity;

   modport source (output valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
                   linear_velocity, angular_velocity, input ready);
   modport sink (input valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
                 linear_velocity, angular_velocity, output ready);
endinterface

@@ hdl/ddo_mul.sv @@
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_mul import ddo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mul_cmd_type        cmd,
   input  logic signed [34:0] mcand,
   input  logic signed [63:0] mplier,
   output unit_stat_type      stat,
   output logic signed [35:0] p_hi,
   output logic [63:0]        p_lo
);

   logic               busy_ff, done_ff;
   logic [5:0]         cnt_ff, last_ff;
   logic signed [34:0] m_ff;
   logic signed [35:0] hi_ff, hi_in;
   logic [63:0]        q_ff, q_in;
   logic signed [36:0] add, t;

   // add (or subtract on the sign bit) and shift one place right
   always_comb begin
      if (q_ff[0]) begin
         add = (cnt_ff == last_ff) ? -37'(m_ff) : 37'(m_ff);
      end else begin
         add = '0;
      end
      t = 37'(hi_ff) + add;
      hi_in = t[36:1];
      q_in = {t[0], q_ff[63:1]};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == last_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         last_ff <= cmd.last;
         m_ff <= mcand;
         hi_ff <= '0;
         q_ff <= mplier;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         q_ff <= q_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign p_hi = hi_ff;
   assign p_lo = q_ff;

endmodule

@@ hdl/ddo_div.sv @@
// restoring signed divider by a 24-bit unsigned divisor, one quotient bit per cycle
// depends on ddo_pkg
`timescale 1ns / 1ps

module ddo_div import ddo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [23:0]        divisor,
   output unit_stat_type      stat,
   output logic signed [63:0] quotient
);

   logic        busy_ff, done_ff, neg_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] q_ff, q_in;
   logic [23:0] rem_ff, rem_in, d_ff;
   logic [24:0] r2, diff;
   logic        ge;

   // one restoring step
   always_comb begin
      r2 = {rem_ff, q_ff[63]};
      diff = r2 - {1'b0, d_ff};
      ge = (r2 >= {1'b0, d_ff});
      rem_in = ge ? diff[23:0] : r2[23:0];
      q_in = {q_ff[62:0], ge};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath on magnitudes, sign applied at the end
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[63];
         q_ff <= dividend[63] ? 64'(-dividend) : 64'(dividend);
         rem_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient = neg_ff ? -signed'(q_ff) : signed'(q_ff);

endmodule

@@ hdl/differential_drive_odometry_top.sv @@
// differential drive wheel odometry, top level with sequencer and rotation unit
// depends on ddo_pkg, ddo_if, ddo_mul, ddo_div
`timescale 1ns / 1ps

// Use: each req beat carries the cumulative right and left wheel travel, the
// microseconds since the previous beat and a flag that says whether the travel
// readings are good; a bad reading reuses the previous ones. Each req beat
// gives exactly one rsp beat with x, y, heading, yaw quaternion z/w and the
// saturated linear and angular velocities. The wheel base is written through
// csr_we/csr_wdata; the user writes it only while no item is in flight, the block does not enforce it.
// Sequence: one item at a time, as three divisions, five bit-serial multiplies
// and two rotations, all run one after another on one shared multiplier,
// divider and rotation unit.
// req ready is high only while the sequencer is idle.
// Stall: the result sits in an output register, so the next item is accepted
// and worked on while the previous beat waits; the sequencer holds in its
// last step only if a new result is ready before the old one was taken.
// Reset: pose, heading and previous readings clear to zero, the wheel base
// goes to 0.54 m, and no rsp beat is pending.

module differential_drive_odometry_top import ddo_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ddo_req_if.sink          req_ch,
   ddo_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [23:0]      csr_wdata
);

   ddo_state_type state_ff, state_in;

   logic [23:0]        wheel_base_ff, wb_eff, us_ff;
   logic signed [31:0] rt_ff, lt_ff, last_right_ff, last_left_ff;
   logic signed [32:0] dr, dl, ds_ff;
   logic signed [33:0] dsum, dd_ff;
   logic signed [49:0] dth_ff;
   logic [31:0]        bam_ff, heading_ff, mid, h_new, half, rot_ang;
   logic signed [38:0] dx_ff, dy_ff;
   logic signed [47:0] accum_x_ff, accum_y_ff;
   logic signed [48:0] sum_x, sum_y;
   logic signed [31:0] vx_ff, vth_ff;

   // rotation unit
   logic signed [33:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic signed [33:0] sh_x, sh_y, atan_z, cos_v, sin_v, z0;
   logic [5:0]         iter_ff;
   logic               flip_ff, rot_flip, rot_load;

   // shared units
   mul_cmd_type        mul_cmd;
   logic signed [34:0] mul_mcand;
   logic signed [63:0] mul_mplier;
   unit_stat_type      mul_stat, div_stat;
   logic signed [35:0] mul_hi;
   logic [63:0]        mul_lo;
   logic               div_start;
   logic signed [63:0] div_dividend, div_quot;
   logic [23:0]        div_divisor;

   // output register
   logic               rsp_valid_ff, req_fire, rsp_load;
   logic signed [47:0] out_x_ff, out_y_ff;
   logic signed [31:0] out_h_ff, out_vx_ff, out_vth_ff;
   logic signed [15:0] out_qz_ff, out_qw_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign wb_eff = (wheel_base_ff == 24'd0) ? 24'd1 : wheel_base_ff;

   ddo_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .mcand  (mul_mcand),
      .mplier (mul_mplier),
      .stat   (mul_stat),
      .p_hi   (mul_hi),
      .p_lo   (mul_lo)
   );

   ddo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // wheel deltas and their sum, mid-step and new heading, half angle and position sums
   always_comb begin
      dr = 33'(rt_ff) - 33'(last_right_ff);
      dl = 33'(lt_ff) - 33'(last_left_ff);
      dsum = 34'(dr) + 34'(dl);
      mid = heading_ff + mul_lo[62:31];
      h_new = heading_ff + bam_ff;
      half = {h_new[31], h_new[31:1]};
      sum_x = 49'(accum_x_ff) + 49'(dx_ff);
      sum_y = 49'(accum_y_ff) + 49'(dy_ff);
   end

   // rotation step and load values
   always_comb begin
      sh_x = cx_ff >>> iter_ff[4:0];
      sh_y = cy_ff >>> iter_ff[4:0];
      atan_z = {2'b00, atan_bam(iter_ff[4:0])};
      if (!cz_ff[33]) begin
         cx_in = cx_ff - sh_y;
         cy_in = cy_ff + sh_x;
         cz_in = cz_ff - atan_z;
      end else begin
         cx_in = cx_ff + sh_y;
         cy_in = cy_ff - sh_x;
         cz_in = cz_ff + atan_z;
      end
      rot_load = ((state_ff == ST_MUL_BAM) && mul_stat.done) || (state_ff == ST_POS);
      rot_ang = (state_ff == ST_MUL_BAM) ? mid : half;
      rot_flip = rot_ang[31] ^ rot_ang[30];
      z0 = 34'(signed'({rot_ang[31] ^ rot_flip, rot_ang[30:0]}));
      cos_v = flip_ff ? -cx_ff : cx_ff;
      sin_v = flip_ff ? -cy_ff : cy_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_DELTA;
         ST_DELTA:    state_in = ST_DIV_DTH;
         ST_DIV_DTH:  if (div_stat.done) state_in = ST_MUL_BAM;
         ST_MUL_BAM:  if (mul_stat.done) state_in = ST_ROT_MID;
         ST_ROT_MID:  if (iter_ff == CORDIC_LAST) state_in = ST_MUL_X;
         ST_MUL_X:    if (mul_stat.done) state_in = ST_MUL_Y;
         ST_MUL_Y:    if (mul_stat.done) state_in = ST_POS;
         ST_POS:      state_in = ST_ROT_HALF;
         ST_ROT_HALF: if (iter_ff == CORDIC_LAST) state_in = ST_MUL_VX;
         ST_MUL_VX:   if (mul_stat.done) state_in = ST_DIV_VX;
         ST_DIV_VX:   if (div_stat.done) state_in = ST_MUL_VTH;
         ST_MUL_VTH:  if (mul_stat.done) state_in = ST_DIV_VTH;
         ST_DIV_VTH:  if (div_stat.done) state_in = ST_DONE;
         ST_DONE:     if (rsp_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // unit commands and operand selection
   always_comb begin
      mul_cmd.start = (state_ff inside {ST_MUL_BAM, ST_MUL_X, ST_MUL_Y, ST_MUL_VX,
                                        ST_MUL_VTH}) && !mul_stat.busy && !mul_stat.done;
      div_start = (state_ff inside {ST_DIV_DTH, ST_DIV_VX, ST_DIV_VTH}) &&
                  !div_stat.busy && !div_stat.done;
      mul_cmd.last = DS_LAST;
      mul_mcand = USEC;
      mul_mplier = 64'(ds_ff);
      div_dividend = 64'(signed'({dd_ff, 16'h0000}));
      div_divisor = wb_eff;
      case (state_ff)
         ST_MUL_BAM: begin
            mul_cmd.last = DTH_LAST;
            mul_mcand = BAM_PER_RAD;
            mul_mplier = 64'(dth_ff);
         end
         ST_MUL_X:   mul_mcand = 35'(cos_v);
         ST_MUL_Y:   mul_mcand = 35'(sin_v);
         ST_MUL_VTH: begin
            mul_cmd.last = DTH_LAST;
            mul_mplier = 64'(dth_ff);
         end
         ST_DIV_VX: begin
            div_dividend = signed'({mul_hi[30:0], mul_lo[63:31]});
            div_divisor = us_ff;
         end
         ST_DIV_VTH: begin
            div_dividend = signed'({mul_hi[13:0], mul_lo[63:14]});
            div_divisor = us_ff;
         end
         default: ;
      endcase
   end

   // sequencer state, configuration and odometry state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wheel_base_ff <= WHEEL_BASE_RESET;
         last_right_ff <= '0;
         last_left_ff <= '0;
         heading_ff <= '0;
         accum_x_ff <= '0;
         accum_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) wheel_base_ff <= csr_wdata;
         if (state_ff == ST_DELTA) begin
            last_right_ff <= rt_ff;
            last_left_ff <= lt_ff;
         end
         if (state_ff == ST_POS) begin
            heading_ff <= h_new;
            if (sum_x[48] != sum_x[47]) accum_x_ff <= sum_x[48] ? POS_MIN : POS_MAX;
            else accum_x_ff <= sum_x[47:0];
            if (sum_y[48] != sum_y[47]) accum_y_ff <= sum_y[48] ? POS_MIN : POS_MAX;
            else accum_y_ff <= sum_y[47:0];
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rt_ff <= req_ch.reading_valid ? req_ch.right_total : last_right_ff;
         lt_ff <= req_ch.reading_valid ? req_ch.left_total : last_left_ff;
         us_ff <= (req_ch.elapsed_us == 24'd0) ? 24'd1 : req_ch.elapsed_us;
      end
      if (state_ff == ST_DELTA) begin
         ds_ff <= dsum[33:1];
         dd_ff <= 34'(dr) - 34'(dl);
      end
      if (state_ff == ST_DIV_DTH && div_stat.done) dth_ff <= div_quot[49:0];
      if (state_ff == ST_MUL_BAM && mul_stat.done) bam_ff <= mul_lo[61:30];
      if (state_ff == ST_MUL_X && mul_stat.done) dx_ff <= signed'({mul_hi, mul_lo[63:61]});
      if (state_ff == ST_MUL_Y && mul_stat.done) dy_ff <= signed'({mul_hi, mul_lo[63:61]});
      if (state_ff == ST_DIV_VX && div_stat.done) vx_ff <= sat32(div_quot);
      if (state_ff == ST_DIV_VTH && div_stat.done) begin
         if (dth_ff > DTH_LIMIT) vth_ff <= V_MAX;
         else if (dth_ff < -DTH_LIMIT) vth_ff <= V_MIN;
         else vth_ff <= sat32(div_quot);
      end
      // rotation unit registers
      if (rot_load) begin
         cx_ff <= CORDIC_X0;
         cy_ff <= '0;
         cz_ff <= z0;
         flip_ff <= rot_flip;
         iter_ff <= '0;
      end else if (state_ff == ST_ROT_MID || state_ff == ST_ROT_HALF) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         iter_ff <= iter_ff + 6'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_x_ff <= accum_x_ff;
         out_y_ff <= accum_y_ff;
         out_h_ff <= heading_ff;
         out_qz_ff <= to_q15(sin_v);
         out_qw_ff <= to_q15(cos_v);
         out_vx_ff <= vx_ff;
         out_vth_ff <= vth_ff;
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pos_x = out_x_ff;
   assign rsp_ch.pos_y = out_y_ff;
   assign rsp_ch.heading_angle = out_h_ff;
   assign rsp_ch.quat_z = out_qz_ff;
   assign rsp_ch.quat_w = out_qw_ff;
   assign rsp_ch.linear_velocity = out_vx_ff;
   assign rsp_ch.angular_velocity = out_vth_ff;

endmodule

@@ hdl/ddo_checker.sv @@
// port-level checks of the wheel odometry top level, attached by bind
// depends on assert_macros.svh and differential_drive_odometry_top
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ddo_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_pos_x
);

   // a stalled result beat stays and holds its x position
   `ASSERT_HOLD(a_rsp_valid_hold, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_HOLD(a_rsp_pos_hold, rsp_valid && !rsp_ready, rsp_pos_x)
   // one item at a time: ready drops after an accepted beat
   `ASSERT_CLK(a_one_in_flight, (req_valid && req_ready) |=> !req_ready)
   // a result never rises in the cycle after acceptance
   `ASSERT_CLK(a_no_instant_rsp, (req_valid && req_ready) |=> !$rose(rsp_valid))

endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_pos_x (rsp_ch.pos_x)
);
